// File: hw/rtl/qse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qse_pkg: shared types and constants
// Types, sizes and helpers used by the queue front end, the execution unit
// and the top level.
// ----------------------------------------------------------------------------
package qse_pkg;

  localparam int DEPTH       = 128;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int CAP_W       = 8;
  localparam int CAP_DEFAULT = 100;
  localparam int EC_W        = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int COUNT_W     = 8;
  localparam int DATA_W      = 32;

  localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_ROT = 2'd2,
    OP_QRY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FEW   = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_t                  status;
    logic [COUNT_W-1:0]       count;
    logic signed [DATA_W-1:0] back_value;
    logic signed [DATA_W-1:0] second_largest;
    logic signed [DATA_W-1:0] second_smallest;
    logic                     found_second;
  } out_item_t;

  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] value;
  } cmd_entry_t;

  typedef struct packed {
    logic       valid;
    cmd_entry_t entry;
  } cmd_link_t;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // Zero selects the default capacity; anything beyond the ring saturates.
  function automatic logic [EC_W-1:0] eff_capacity(input logic [CAP_W-1:0] c);
    logic [EC_W-1:0] e;
    e = (c == '0) ? EC_W'(CAP_DEFAULT) : EC_W'(c);
    if (e > EC_W'(DEPTH)) e = EC_W'(DEPTH);
    return e;
  endfunction

endpackage

// File: hw/rtl/qse_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qse_front: command intake
// Accepts commands, decodes the operation and holds them in a two-entry
// queue until the execution unit takes them.
// ----------------------------------------------------------------------------
module qse_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  qse_pkg::in_item_t   in_item,
  output logic                busy,
  output qse_pkg::cmd_link_t  cmd,
  input  logic                pop
);

  qse_pkg::cmd_entry_t slots [2];
  logic [1:0] fill;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;

  assign busy = (fill == 2'd2);
  assign push = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].op    <= qse_pkg::op_t'(in_item.kind);
      slots[wr_ptr].value <= in_item.value;
    end
  end

  assign cmd.valid = (fill != 2'd0);
  assign cmd.entry = slots[rd_ptr];

endmodule

// File: hw/rtl/qse_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qse_back: queue execution unit
// Owns the ring memory, the head, tail and count registers and the capacity
// register, carries out one command at a time and registers its result.
// ----------------------------------------------------------------------------
module qse_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [qse_pkg::CAP_W-1:0] cfg_data,
  input  qse_pkg::cmd_link_t        cmd,
  output logic                      pop,
  output logic                      done,
  output qse_pkg::out_item_t        result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ROT,
    S_SCAN,
    S_QEND
  } state_t;

  state_t state;

  logic signed [qse_pkg::DATA_W-1:0] mem [qse_pkg::DEPTH];

  logic [qse_pkg::CAP_W-1:0]  capacity;
  logic [qse_pkg::IDX_W-1:0]  head;
  logic [qse_pkg::IDX_W-1:0]  tail;
  logic [qse_pkg::CNT_W-1:0]  held;
  logic signed [qse_pkg::DATA_W-1:0] back_reg;
  qse_pkg::cmd_entry_t        cur;

  logic [qse_pkg::IDX_W-1:0]  scan_ptr;
  logic [qse_pkg::CNT_W-1:0]  scan_left;
  logic [qse_pkg::CNT_W-1:0]  proc_left;
  logic signed [qse_pkg::DATA_W-1:0] lg, sl, sm, ss;
  logic signed [qse_pkg::DATA_W-1:0] lg_next, sl_next, sm_next, ss_next;

  logic                       mem_we;
  logic [qse_pkg::IDX_W-1:0]  mem_wa;
  logic signed [qse_pkg::DATA_W-1:0] mem_wd;
  logic                       rd_en;
  logic [qse_pkg::IDX_W-1:0]  rd_addr;
  logic signed [qse_pkg::DATA_W-1:0] rd_data;

  logic                       is_full;
  logic                       is_empty;

  assign is_full  = (qse_pkg::EC_W'(held) >= qse_pkg::eff_capacity(capacity));
  assign is_empty = (held == '0);
  assign pop      = (state == S_IDLE) && cmd.valid;

  // Memory port control follows the state and the current command.
  always_comb begin
    mem_we  = 1'b0;
    mem_wa  = tail;
    mem_wd  = cur.value;
    rd_en   = 1'b0;
    rd_addr = head;
    case (state)
      S_EXEC: begin
        case (cur.op)
          qse_pkg::OP_ENQ: mem_we = !is_full;
          qse_pkg::OP_ROT: rd_en = (held > qse_pkg::CNT_W'(1));
          qse_pkg::OP_QRY: rd_en = (held > qse_pkg::CNT_W'(1));
          default: ;
        endcase
      end
      S_ROT: begin
        mem_we = 1'b1;
        mem_wd = rd_data;
      end
      S_SCAN: begin
        rd_en   = (scan_left != '0);
        rd_addr = scan_ptr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Running first and second extremes, updated with the entry just read.
  always_comb begin
    lg_next = lg;
    sl_next = sl;
    sm_next = sm;
    ss_next = ss;
    if (rd_data > lg) begin
      sl_next = lg;
      lg_next = rd_data;
    end else if (rd_data > sl && rd_data != lg) begin
      sl_next = rd_data;
    end
    if (rd_data < sm) begin
      ss_next = sm;
      sm_next = rd_data;
    end else if (rd_data < ss && rd_data != sm) begin
      ss_next = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      capacity <= qse_pkg::CAP_W'(qse_pkg::CAP_DEFAULT);
      head     <= '0;
      tail     <= '0;
      held     <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_we) capacity <= cfg_data;
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            cur   <= cmd.entry;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          done                   <= 1'b1;
          result.status          <= qse_pkg::ST_DONE;
          result.count           <= qse_pkg::COUNT_W'(held);
          result.back_value      <= is_empty ? '0 : back_reg;
          result.second_largest  <= qse_pkg::INT_MIN;
          result.second_smallest <= qse_pkg::INT_MAX;
          result.found_second    <= 1'b0;
          state                  <= S_IDLE;
          case (cur.op)
            qse_pkg::OP_ENQ: begin
              if (is_full) begin
                result.status <= qse_pkg::ST_FULL;
              end else begin
                tail              <= qse_pkg::next_idx(tail);
                held              <= held + 1'b1;
                back_reg          <= cur.value;
                result.count      <= qse_pkg::COUNT_W'(held + 1'b1);
                result.back_value <= cur.value;
              end
            end
            qse_pkg::OP_DEQ: begin
              if (is_empty) begin
                result.status <= qse_pkg::ST_EMPTY;
              end else begin
                head         <= qse_pkg::next_idx(head);
                held         <= held - 1'b1;
                result.count <= qse_pkg::COUNT_W'(held - 1'b1);
                if (held == qse_pkg::CNT_W'(1)) result.back_value <= '0;
              end
            end
            qse_pkg::OP_ROT: begin
              if (is_empty) begin
                result.status <= qse_pkg::ST_EMPTY;
              end else if (held > qse_pkg::CNT_W'(1)) begin
                done  <= 1'b0;
                state <= S_ROT;
              end
            end
            qse_pkg::OP_QRY: begin
              if (held < qse_pkg::CNT_W'(2)) begin
                result.status <= qse_pkg::ST_FEW;
              end else begin
                done      <= 1'b0;
                scan_ptr  <= qse_pkg::next_idx(head);
                scan_left <= held - 1'b1;
                proc_left <= held;
                lg        <= qse_pkg::INT_MIN;
                sl        <= qse_pkg::INT_MIN;
                sm        <= qse_pkg::INT_MAX;
                ss        <= qse_pkg::INT_MAX;
                state     <= S_SCAN;
              end
            end
            default: ;
          endcase
        end
        S_ROT: begin
          // The front entry read last cycle is written at the tail.
          head                   <= qse_pkg::next_idx(head);
          tail                   <= qse_pkg::next_idx(tail);
          back_reg               <= rd_data;
          done                   <= 1'b1;
          result.back_value      <= rd_data;
          state                  <= S_IDLE;
        end
        S_SCAN: begin
          lg        <= lg_next;
          sl        <= sl_next;
          sm        <= sm_next;
          ss        <= ss_next;
          proc_left <= proc_left - 1'b1;
          if (scan_left != '0) begin
            scan_ptr  <= qse_pkg::next_idx(scan_ptr);
            scan_left <= scan_left - 1'b1;
          end
          if (proc_left == qse_pkg::CNT_W'(1)) state <= S_QEND;
        end
        S_QEND: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (lg != sm) begin
            result.found_second    <= 1'b1;
            result.second_largest  <= sl;
            result.second_smallest <= ss;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/queue_with_second_extremes.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queue_with_second_extremes: bounded queue with second extreme search
// Ring queue of signed 32-bit values with enqueue, dequeue, rotate and a
// scan for the second largest and second smallest distinct values.
// ----------------------------------------------------------------------------
// Usage:
//   A command (in_item.kind, in_item.value) is taken at a rising edge with
//   start high and busy low. Commands wait in a two-entry queue in front of
//   the execution unit; busy is high while that queue is full.
//   Every command yields one result on the result port, flagged by done for
//   exactly one cycle. The receiver cannot stall, so it must take it then.
//   Each command goes from the queue to the execute state; enqueue, dequeue
//   and the trivial cases finish there, a rotate goes on through a write-back
//   state and a query through a scan state and a final state. The execution
//   unit runs one command at a time and takes no new one before it is through
//   with the last; the scan walks the single read port of the ring memory one
//   entry per cycle. cfg_we/cfg_data write the capacity register; the user
//   must do so only while no command is pending, which the block does not
//   enforce. Synchronous reset rst empties the queue, sets capacity to 100
//   and drops any queued commands; the ring contents are not cleared.
// ----------------------------------------------------------------------------
module queue_with_second_extremes (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  qse_pkg::in_item_t         in_item,
  output logic                      busy,
  input  logic                      cfg_we,
  input  logic [qse_pkg::CAP_W-1:0] cfg_data,
  output logic                      done,
  output qse_pkg::out_item_t        result
);

  qse_pkg::cmd_link_t cmd;
  logic               pop;

  qse_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .in_item (in_item),
    .busy    (busy),
    .cmd     (cmd),
    .pop     (pop)
  );

  qse_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .pop      (pop),
    .done     (done),
    .result   (result)
  );

endmodule

// File: hw/rtl/qse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qse_checker: port-level checks
// Watches the top-level ports and checks the consistency of results.
// ----------------------------------------------------------------------------
module qse_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      done,
  input qse_pkg::out_item_t        result
);

  // A transaction is needed before any result can appear after reset.
  a_no_done_after_reset: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    done && result.status == qse_pkg::ST_EMPTY |->
      result.count == '0 && result.back_value == '0)
    else $error("empty status with entries held");

  // Only a completed query with two or more entries can find the second extremes.
  a_found_is_ok: assert property (@(posedge clk) disable iff (rst)
    done && result.found_second |->
      result.status == qse_pkg::ST_DONE && result.count >= 8'd2)
    else $error("second extremes flagged on a short or failed query");

  a_few_count: assert property (@(posedge clk) disable iff (rst)
    done && result.status == qse_pkg::ST_FEW |->
      result.count < 8'd2 && !result.found_second)
    else $error("short-queue status with two or more entries");

  // Every result is flagged by done for exactly one cycle.
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

endmodule

bind queue_with_second_extremes qse_checker u_qse_checker (
  .clk    (clk),
  .rst    (rst),
  .done   (done),
  .result (result)
);
